// File: rtl/fjik_pkg.sv
package fjik_pkg;

    // CORDIC vectoring depth, the CORDIC stage count that follows from it, and the square-root depth.
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_LAT        = CORDIC_ITERATIONS + 2;
    localparam int SQRT_STAGES       = 14;

    // Datapath widths.
    localparam int IW = 28;          // CORDIC operand width before the 8-bit prescale
    localparam int CW = 40;          // CORDIC x/y width
    localparam int ZW = 28;          // CORDIC angle accumulator, Q.24
    localparam int AW = ZW - 12;     // Rounded angle, Q3.12
    localparam int RW = 28;          // Square-root radicand width

    localparam int HALF_PI_Q12  = 6434;
    localparam int ATAN0_DOUBLE = 26353590;

    // Pipeline stage numbers, counted in clock edges after the input beat.
    localparam int ST_IN    = 1;
    localparam int ST_SQ    = ST_IN + 1;
    localparam int ST_REACH = ST_SQ + SQRT_STAGES;
    localparam int ST_XY    = ST_REACH + 1;
    localparam int ST_SQR   = ST_XY + 1;
    localparam int ST_NUM   = ST_SQR + 1;
    localparam int ST_PROD  = ST_NUM + 1;
    localparam int ST_C     = ST_PROD + 1;
    localparam int ST_RAD   = ST_C + 1;
    localparam int ST_S     = ST_RAD + SQRT_STAGES;
    localparam int ST_TERM  = ST_S + 1;
    localparam int ST_ANG   = ST_TERM + CORDIC_LAT;
    localparam int ST_OUT   = ST_ANG + 1;

    localparam int DLY_Z    = ST_REACH - ST_IN;
    localparam int DLY_XY   = ST_TERM - ST_XY;
    localparam int DLY_C    = ST_S - ST_C;
    localparam int DLY_FLAG = ST_ANG - ST_C;
    localparam int DLY_BASE = ST_ANG - (ST_IN + CORDIC_LAT);

    // Configuration register map.
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_BASE_HEIGHT     = 3'd0;
    localparam logic [2:0] REG_UPPER_LINK      = 3'd1;
    localparam logic [2:0] REG_UPPER_OFFSET    = 3'd2;
    localparam logic [2:0] REG_FOREARM         = 3'd3;
    localparam logic [2:0] REG_TOOL_REACH      = 3'd4;
    localparam logic [2:0] REG_MARKER_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_COSINE_SCALE    = 3'd6;

    localparam logic [13:0] RST_BASE_HEIGHT    = 14'd2360;
    localparam logic [13:0] RST_UPPER_LINK     = 14'd2802;
    localparam logic [12:0] RST_UPPER_OFFSET   = 13'd1413;
    localparam logic [13:0] RST_FOREARM        = 14'd2509;
    localparam logic [13:0] RST_TOOL_REACH     = 14'd2918;
    localparam logic [13:0] RST_MARKER_HEIGHT  = 14'd1280;
    localparam logic [23:0] RST_COSINE_SCALE   = 24'd78214;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_state_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] root;
    } sqrt_state_t;

    // Elementary angles atan(2^-i) in Q.24.
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = ZW'(13176795);
            5'd1:    r = ZW'(7778716);
            5'd2:    r = ZW'(4110060);
            5'd3:    r = ZW'(2086331);
            5'd4:    r = ZW'(1047214);
            5'd5:    r = ZW'(524117);
            5'd6:    r = ZW'(262123);
            5'd7:    r = ZW'(131069);
            5'd8:    r = ZW'(65536);
            5'd9:    r = ZW'(32768);
            5'd10:   r = ZW'(16384);
            5'd11:   r = ZW'(8192);
            5'd12:   r = ZW'(4096);
            5'd13:   r = ZW'(2048);
            5'd14:   r = ZW'(1024);
            5'd15:   r = ZW'(512);
            5'd16:   r = ZW'(256);
            5'd17:   r = ZW'(128);
            5'd18:   r = ZW'(64);
            5'd19:   r = ZW'(32);
            5'd20:   r = ZW'(16);
            5'd21:   r = ZW'(8);
            5'd22:   r = ZW'(4);
            5'd23:   r = ZW'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/fjik_cordic_cell.sv
module fjik_cordic_cell
    import fjik_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [4:0]    idx,
    input  cordic_state_t din,
    output cordic_state_t dout
);

    cordic_state_t        state_reg;
    cordic_state_t        state_next;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] ang;

    assign sx  = din.x >>> idx;
    assign sy  = din.y >>> idx;
    assign ang = atan_entry(idx);

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb
    begin
        state_next.zero = din.zero;
        if (din.y > 0)
        begin
            state_next.x = din.x + sy;
            state_next.y = din.y - sx;
            state_next.z = din.z + ang;
        end
        else
        begin
            state_next.x = din.x - sy;
            state_next.y = din.y + sx;
            state_next.z = din.z - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

// File: rtl/fjik_cordic.sv
module fjik_cordic
    import fjik_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [IW-1:0] y_in,
    input  logic signed [IW-1:0] x_in,
    output logic signed [AW-1:0] angle
);

    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] xs;
    cordic_state_t        pre_reg;
    cordic_state_t        pre_next;
    cordic_state_t        st [CORDIC_ITERATIONS+1];
    logic signed [ZW-1:0] zr;
    logic signed [AW-1:0] angle_reg;
    logic signed [AW-1:0] angle_next;

    assign ys = {{(CW-IW-8){y_in[IW-1]}}, y_in, 8'b0};
    assign xs = {{(CW-IW-8){x_in[IW-1]}}, x_in, 8'b0};

    // A vector in the left half plane is turned by a quarter turn first.
    always_comb
    begin
        pre_next.zero = (y_in == '0) && (x_in == '0);
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                pre_next.x = ys;
                pre_next.y = -xs;
                pre_next.z = ZW'(ATAN0_DOUBLE);
            end
            else
            begin
                pre_next.x = -ys;
                pre_next.y = xs;
                pre_next.z = -ZW'(ATAN0_DOUBLE);
            end
        end
        else
        begin
            pre_next.x = xs;
            pre_next.y = ys;
            pre_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
        end
    end

    assign st[0] = pre_reg;

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++)
    begin : g_cell
        fjik_cordic_cell u_cell (
            .clk  (clk),
            .en   (en),
            .idx  (5'(i)),
            .din  (st[i]),
            .dout (st[i+1])
        );
    end

    // Round half up from Q.24 to Q3.12.
    assign zr         = st[CORDIC_ITERATIONS].z + ZW'(2048);
    assign angle_next = st[CORDIC_ITERATIONS].zero ? '0 : zr[ZW-1:12];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// File: rtl/fjik_sqrt_cell.sv
module fjik_sqrt_cell
    import fjik_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [3:0]  idx,
    input  sqrt_state_t din,
    output sqrt_state_t dout
);

    sqrt_state_t   state_reg;
    sqrt_state_t   state_next;
    logic [4:0]    sh;
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;

    assign sh    = 5'(RW - 2) - {idx, 1'b0};
    assign bitv  = RW'(1) << sh;
    assign trial = din.root + bitv;

    always_comb
    begin
        if (din.rem >= trial)
        begin
            state_next.rem  = din.rem - trial;
            state_next.root = (din.root >> 1) + bitv;
        end
        else
        begin
            state_next.rem  = din.rem;
            state_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

// File: rtl/fjik_sqrt.sv
module fjik_sqrt
    import fjik_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [RW-1:0]          radicand,
    output logic [SQRT_STAGES-1:0] root
);

    sqrt_state_t st [SQRT_STAGES+1];

    assign st[0].rem  = radicand;
    assign st[0].root = '0;

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_cell
        fjik_sqrt_cell u_cell (
            .clk  (clk),
            .en   (en),
            .idx  (4'(i)),
            .din  (st[i]),
            .dout (st[i+1])
        );
    end

    assign root = st[SQRT_STAGES].root[SQRT_STAGES-1:0];

endmodule

// File: rtl/four_joint_arm_inverse_kinematics.sv
// Throughput: one target per cycle; every stage is a register, most in chains of
// square-root and CORDIC cells, so a new beat enters each cycle the output is free.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// link geometry registers with their default values.
module four_joint_arm_inverse_kinematics
    import fjik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0: target_x[13:0], target_y[27:14], target_z[41:28], zero pad.
    input  logic [47:0]       s_axis_tdata,

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Fields from bit 0: base_angle, shoulder_angle, elbow_angle, wrist_angle (16 each).
    output logic [63:0]       m_axis_tdata,
    // Fields from bit 0: unreachable.
    output logic [0:0]        m_axis_tuser
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase of the
    // bus; reads return the stored value and nothing past the map.
    // ------------------------------------------------------------------
    logic [13:0] base_height_reg;
    logic [13:0] upper_link_reg;
    logic [12:0] upper_offset_reg;
    logic [13:0] forearm_reg;
    logic [13:0] tool_reach_reg;
    logic [13:0] marker_height_reg;
    logic [23:0] cosine_scale_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg   <= RST_BASE_HEIGHT;
            upper_link_reg    <= RST_UPPER_LINK;
            upper_offset_reg  <= RST_UPPER_OFFSET;
            forearm_reg       <= RST_FOREARM;
            tool_reach_reg    <= RST_TOOL_REACH;
            marker_height_reg <= RST_MARKER_HEIGHT;
            cosine_scale_reg  <= RST_COSINE_SCALE;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_BASE_HEIGHT:   base_height_reg   <= pwdata[13:0];
                REG_UPPER_LINK:    upper_link_reg    <= pwdata[13:0];
                REG_UPPER_OFFSET:  upper_offset_reg  <= pwdata[12:0];
                REG_FOREARM:       forearm_reg       <= pwdata[13:0];
                REG_TOOL_REACH:    tool_reach_reg    <= pwdata[13:0];
                REG_MARKER_HEIGHT: marker_height_reg <= pwdata[13:0];
                REG_COSINE_SCALE:  cosine_scale_reg  <= pwdata[23:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BASE_HEIGHT:   prdata = {18'b0, base_height_reg};
            REG_UPPER_LINK:    prdata = {18'b0, upper_link_reg};
            REG_UPPER_OFFSET:  prdata = {19'b0, upper_offset_reg};
            REG_FOREARM:       prdata = {18'b0, forearm_reg};
            REG_TOOL_REACH:    prdata = {18'b0, tool_reach_reg};
            REG_MARKER_HEIGHT: prdata = {18'b0, marker_height_reg};
            REG_COSINE_SCALE:  prdata = {8'b0, cosine_scale_reg};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipe advances together whenever the
    // output register is empty or its beat is being taken, so the block
    // takes a new beat in the same cycle a finished result leaves.
    // ------------------------------------------------------------------
    logic              adv;
    logic [ST_OUT:1]   vld_reg;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ST_OUT-1:1], s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Input stage and radial reach squared.
    // ------------------------------------------------------------------
    logic signed [13:0]   x_reg;
    logic signed [13:0]   y_reg;
    logic signed [13:0]   z_reg;
    logic signed [27:0]   xx;
    logic signed [27:0]   yy;
    logic [RW-1:0]        sq_reg;
    logic [RW-1:0]        sq_next;

    assign xx      = x_reg * x_reg;
    assign yy      = y_reg * y_reg;
    assign sq_next = RW'($unsigned(xx)) + RW'($unsigned(yy));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg  <= s_axis_tdata[13:0];
            y_reg  <= s_axis_tdata[27:14];
            z_reg  <= s_axis_tdata[41:28];
            sq_reg <= sq_next;
        end
    end

    // Base yaw runs in parallel with the rest of the solution.
    logic signed [IW-1:0] base_y;
    logic signed [IW-1:0] base_x;
    logic signed [AW-1:0] base_ang;

    assign base_y = {{(IW-26){y_reg[13]}}, y_reg, 12'b0};
    assign base_x = {{(IW-26){x_reg[13]}}, x_reg, 12'b0};

    fjik_cordic u_cordic_base (
        .clk   (clk),
        .en    (adv),
        .y_in  (base_y),
        .x_in  (base_x),
        .angle (base_ang)
    );

    // Radial reach: floor of the square root of x^2 + y^2.
    logic [SQRT_STAGES-1:0] reach;

    fjik_sqrt u_sqrt_reach (
        .clk      (clk),
        .en       (adv),
        .radicand (sq_reg),
        .root     (reach)
    );

    // Height travels alongside the square-root chain.
    logic signed [13:0] z_dly_reg [DLY_Z];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_dly_reg[0] <= z_reg;
            for (int i = 1; i < DLY_Z; i++)
            begin
                z_dly_reg[i] <= z_dly_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Planar target, law-of-cosines numerator and scaled cosine.
    // ------------------------------------------------------------------
    logic signed [15:0] xr_reg;
    logic signed [15:0] yr_reg;
    logic signed [15:0] xr_next;
    logic signed [15:0] yr_next;

    assign xr_next = $signed({2'b0, reach}) - $signed({2'b0, tool_reach_reg});
    assign yr_next = 16'(z_dly_reg[DLY_Z-1]) + $signed({2'b0, marker_height_reg})
                   - $signed({2'b0, base_height_reg});

    logic signed [31:0] xr2;
    logic signed [31:0] yr2;
    logic [27:0]        uu;
    logic [27:0]        ff;
    logic [29:0]        xr2_reg;
    logic [29:0]        yr2_reg;
    logic [27:0]        uu_reg;
    logic [27:0]        ff_reg;
    logic signed [31:0] num_reg;
    logic signed [31:0] num_next;
    logic signed [56:0] prod_reg;
    logic signed [56:0] prod_next;
    logic signed [56:0] rnd;
    logic signed [28:0] craw;
    logic signed [13:0] c_reg;
    logic signed [13:0] c_next;
    logic               flag_reg;
    logic               flag_next;

    assign xr2 = xr_reg * xr_reg;
    assign yr2 = yr_reg * yr_reg;
    assign uu  = upper_link_reg * upper_link_reg;
    assign ff  = forearm_reg * forearm_reg;

    assign num_next  = $signed({2'b0, xr2_reg}) + $signed({2'b0, yr2_reg})
                     - $signed({4'b0, uu_reg}) - $signed({4'b0, ff_reg});
    assign prod_next = num_reg * $signed({1'b0, cosine_scale_reg});
    assign rnd       = prod_reg + 57'sd134217728;
    assign craw      = rnd[56:28];

    // An elbow cosine beyond unit magnitude is pinned and reported.
    always_comb
    begin
        if (craw > 29'sd4096)
        begin
            c_next    = 14'sd4096;
            flag_next = 1'b1;
        end
        else if (craw < -29'sd4096)
        begin
            c_next    = -14'sd4096;
            flag_next = 1'b1;
        end
        else
        begin
            c_next    = craw[13:0];
            flag_next = 1'b0;
        end
    end

    // Sine term radicand: 1 - c^2 in unsigned Q4.24.
    logic signed [27:0] csq;
    logic [RW-1:0]      rad_reg;

    assign csq = c_reg * c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xr_reg   <= xr_next;
            yr_reg   <= yr_next;
            xr2_reg  <= 30'($unsigned(xr2));
            yr2_reg  <= 30'($unsigned(yr2));
            uu_reg   <= uu;
            ff_reg   <= ff;
            num_reg  <= num_next;
            prod_reg <= prod_next;
            c_reg    <= c_next;
            flag_reg <= flag_next;
            rad_reg  <= RW'(1 << 24) - RW'($unsigned(csq));
        end
    end

    logic [SQRT_STAGES-1:0] s_root;

    fjik_sqrt u_sqrt_sine (
        .clk      (clk),
        .en       (adv),
        .radicand (rad_reg),
        .root     (s_root)
    );

    // ------------------------------------------------------------------
    // Side data waits for the sine chain and the three angle chains.
    // ------------------------------------------------------------------
    logic signed [15:0]   xr_dly_reg   [DLY_XY];
    logic signed [15:0]   yr_dly_reg   [DLY_XY];
    logic signed [13:0]   c_dly_reg    [DLY_C];
    logic                 flag_dly_reg [DLY_FLAG];
    logic signed [AW-1:0] base_dly_reg [DLY_BASE];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xr_dly_reg[0]   <= xr_reg;
            yr_dly_reg[0]   <= yr_reg;
            c_dly_reg[0]    <= c_reg;
            flag_dly_reg[0] <= flag_reg;
            base_dly_reg[0] <= base_ang;
            for (int i = 1; i < DLY_XY; i++)
            begin
                xr_dly_reg[i] <= xr_dly_reg[i-1];
                yr_dly_reg[i] <= yr_dly_reg[i-1];
            end
            for (int i = 1; i < DLY_C; i++)
            begin
                c_dly_reg[i] <= c_dly_reg[i-1];
            end
            for (int i = 1; i < DLY_FLAG; i++)
            begin
                flag_dly_reg[i] <= flag_dly_reg[i-1];
            end
            for (int i = 1; i < DLY_BASE; i++)
            begin
                base_dly_reg[i] <= base_dly_reg[i-1];
            end
        end
    end

    // Second shoulder term operands: F*s and U*4096 + F*c.
    logic [27:0]          fs_reg;
    logic signed [IW-1:0] xt_reg;
    logic [12:0]          s_term_reg;
    logic signed [13:0]   c_term_reg;
    logic signed [27:0]   fc;

    assign fc = $signed({1'b0, forearm_reg}) * c_dly_reg[DLY_C-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fs_reg     <= forearm_reg * s_root;
            xt_reg     <= $signed({2'b0, upper_link_reg, 12'b0}) + fc;
            s_term_reg <= s_root[12:0];
            c_term_reg <= c_dly_reg[DLY_C-1];
        end
    end

    logic signed [IW-1:0] elb_y;
    logic signed [IW-1:0] elb_x;
    logic signed [IW-1:0] pl_y;
    logic signed [IW-1:0] pl_x;
    logic signed [AW-1:0] elb_ang;
    logic signed [AW-1:0] pl_ang;
    logic signed [AW-1:0] link_ang;

    assign elb_y = {{(IW-13){1'b0}}, s_term_reg};
    assign elb_x = {{(IW-14){c_term_reg[13]}}, c_term_reg};
    assign pl_y  = {xr_dly_reg[DLY_XY-1], 12'b0};
    assign pl_x  = {yr_dly_reg[DLY_XY-1], 12'b0};

    fjik_cordic u_cordic_elbow (
        .clk   (clk),
        .en    (adv),
        .y_in  (elb_y),
        .x_in  (elb_x),
        .angle (elb_ang)
    );

    fjik_cordic u_cordic_plane (
        .clk   (clk),
        .en    (adv),
        .y_in  (pl_y),
        .x_in  (pl_x),
        .angle (pl_ang)
    );

    fjik_cordic u_cordic_link (
        .clk   (clk),
        .en    (adv),
        .y_in  ($signed(fs_reg)),
        .x_in  (xt_reg),
        .angle (link_ang)
    );

    // ------------------------------------------------------------------
    // Joint offsets, wrist, saturation and the output register.
    // ------------------------------------------------------------------
    logic signed [17:0] q2w;
    logic signed [17:0] q3w;
    logic signed [17:0] q4w;
    logic [63:0]        tdata_reg;
    logic               tuser_reg;

    assign q2w = $signed({5'b0, upper_offset_reg}) - (18'(pl_ang) - 18'(link_ang));
    assign q3w = 18'sd6434 - 18'(elb_ang);
    assign q4w = -q2w - q3w;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tdata_reg <= {sat16(q4w), sat16(q3w), sat16(q2w),
                          sat16(18'(base_dly_reg[DLY_BASE-1]))};
            tuser_reg <= flag_dly_reg[DLY_FLAG-1];
        end
    end

    assign m_axis_tdata = tdata_reg;
    assign m_axis_tuser = tuser_reg;

endmodule

// File: rtl/fjik_checker.sv
module fjik_assertions
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic signed [15:0] sh;
    logic signed [15:0] el;
    logic signed [15:0] wr;
    logic signed [17:0] wr_exp;
    logic               small_joints;

    assign sh           = m_axis_tdata[31:16];
    assign el           = m_axis_tdata[47:32];
    assign wr           = m_axis_tdata[63:48];
    assign wr_exp       = -(18'(sh) + 18'(el));
    assign small_joints = (sh > -16'sd16384) && (sh < 16'sd16384)
                       && (el > -16'sd16384) && (el < 16'sd16384);

    // A held result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // The input side is open exactly when the output register can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output state");

    // Once reset has been seen, no result is presented in the next cycle.
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // Wrist is the negated sum of shoulder and elbow when nothing saturates.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && small_joints |-> 18'(wr) == wr_exp)
        else $error("wrist angle inconsistent with shoulder and elbow");

endmodule

bind four_joint_arm_inverse_kinematics fjik_assertions u_fjik_assertions (.*);

// File: dv/fjik_checker.sv
module fjik_checker
    import fjik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] base_ang;
        logic signed [15:0] shoulder_ang;
        logic signed [15:0] elbow_ang;
        logic signed [15:0] wrist_ang;
        logic               clamped;
    } joint_set_t;

    longint geo_base_h, geo_upper, geo_offset, geo_forearm, geo_tool, geo_marker, geo_scale;
    joint_set_t joint_queue[$];

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, bit_w;
        res = 0;
        bit_w = 64'sd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
            begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint ang, nx, ny, step;
        ang = 0;
        if (yv == 0 && xv == 0) return 0;
        yv = yv * 256;
        xv = xv * 256;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                nx = yv; ny = -xv; ang = ATAN0_DOUBLE;
            end
            else
            begin
                nx = -yv; ny = xv; ang = -ATAN0_DOUBLE;
            end
            xv = nx; yv = ny;
        end
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            case (i)
                0: step = 13176795;  1: step = 7778716;  2: step = 4110060;
                3: step = 2086331;   4: step = 1047214;  5: step = 524117;
                6: step = 262123;    7: step = 131069;
                default: step = 64'sd65536 >>> (i - 8);
            endcase
            if (yv > 0)
            begin
                nx = xv + fshift(yv, i); ny = yv - fshift(xv, i); ang = ang + step;
            end
            else
            begin
                nx = xv - fshift(yv, i); ny = yv + fshift(xv, i); ang = ang - step;
            end
            xv = nx; yv = ny;
        end
        return fshift(ang + 2048, 12);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic joint_set_t solve_joints(logic [47:0] d);
        joint_set_t r;
        longint x, y, z, reach, xr, yr, num, c, s, sh, el;
        x = longint'($signed(d[13:0]));
        y = longint'($signed(d[27:14]));
        z = longint'($signed(d[41:28]));
        r.clamped = 1'b0;
        r.base_ang = clip16(vector_angle(y * 4096, x * 4096));
        reach = int_sqrt(x * x + y * y);
        xr = reach - geo_tool;
        yr = z + geo_marker - geo_base_h;
        num = xr * xr + yr * yr - geo_upper * geo_upper - geo_forearm * geo_forearm;
        c = fshift(num * geo_scale + (64'sd1 << 27), 28);
        if (c > 4096)
        begin
            c = 4096; r.clamped = 1'b1;
        end
        if (c < -4096)
        begin
            c = -4096; r.clamped = 1'b1;
        end
        s = int_sqrt((64'sd1 << 24) - c * c);
        el = HALF_PI_Q12 - vector_angle(s, c);
        sh = geo_offset - (vector_angle(xr * 4096, yr * 4096)
             - vector_angle(geo_forearm * s, geo_upper * 4096 + geo_forearm * c));
        r.shoulder_ang = clip16(sh);
        r.elbow_ang = clip16(el);
        r.wrist_ang = clip16(-sh - el);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        joint_set_t want, got;
        if (!rst_n)
        begin
            geo_base_h = RST_BASE_HEIGHT;   geo_upper = RST_UPPER_LINK;
            geo_offset = RST_UPPER_OFFSET;  geo_forearm = RST_FOREARM;
            geo_tool = RST_TOOL_REACH;      geo_marker = RST_MARKER_HEIGHT;
            geo_scale = RST_COSINE_SCALE;
            joint_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_BASE_HEIGHT:   geo_base_h = pwdata[13:0];
                    REG_UPPER_LINK:    geo_upper = pwdata[13:0];
                    REG_UPPER_OFFSET:  geo_offset = pwdata[12:0];
                    REG_FOREARM:       geo_forearm = pwdata[13:0];
                    REG_TOOL_REACH:    geo_tool = pwdata[13:0];
                    REG_MARKER_HEIGHT: geo_marker = pwdata[13:0];
                    REG_COSINE_SCALE:  geo_scale = pwdata[23:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.base_ang = m_axis_tdata[15:0];
                got.shoulder_ang = m_axis_tdata[31:16];
                got.elbow_ang = m_axis_tdata[47:32];
                got.wrist_ang = m_axis_tdata[63:48];
                got.clamped = m_axis_tuser[0];
                if (joint_queue.size() == 0)
                begin
                    $error("result beat with no target pending");
                    fail_count++;
                end
                else
                begin
                    want = joint_queue.pop_front();
                    if (want.base_ang !== got.base_ang)
                    begin
                        $error("base_angle exp %0d got %0d", want.base_ang, got.base_ang);
                        fail_count++;
                    end
                    if (want.shoulder_ang !== got.shoulder_ang)
                    begin
                        $error("shoulder_angle exp %0d got %0d", want.shoulder_ang,
                               got.shoulder_ang);
                        fail_count++;
                    end
                    if (want.elbow_ang !== got.elbow_ang)
                    begin
                        $error("elbow_angle exp %0d got %0d", want.elbow_ang, got.elbow_ang);
                        fail_count++;
                    end
                    if (want.wrist_ang !== got.wrist_ang)
                    begin
                        $error("wrist_angle exp %0d got %0d", want.wrist_ang, got.wrist_ang);
                        fail_count++;
                    end
                    if (want.clamped !== got.clamped)
                    begin
                        $error("unreachable exp %0d got %0d", want.clamped, got.clamped);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                joint_queue.push_back(solve_joints(s_axis_tdata));
        end
        pending_count = joint_queue.size();
    end
endmodule

// File: dv/four_joint_arm_inverse_kinematics_tb.sv
module four_joint_arm_inverse_kinematics_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fjik_pkg::*;

    // Depth of the block's pipeline from an input beat to its result beat.
    localparam int PIPE_DEPTH = 56;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    int fail_count, pending_count;
    int sender_idle_pct, receiver_idle_pct;
    int hold_off_cycles;
    int cycle_count;

    always #5 clk = ~clk;

    four_joint_arm_inverse_kinematics DUT (.*);

    fjik_checker u_checker (.*);

    // The receiver's ready is redrawn on each falling edge; a hold-off request
    // forces it low for a counted number of cycles while the sender keeps going.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** four_joint_arm_inverse_kinematics: FAILED **");
            $finish;
        end
    end

    task automatic write_geometry(input logic [2:0] reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(reg_idx) << 2; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offers one target beat and holds it until the block takes it.
    task automatic send_target(input logic [13:0] tx, input logic [13:0] ty,
                               input logic [13:0] tz);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, tz, ty, tx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    // Targets are mostly drawn near the arm's working envelope so that the
    // cosine stays in range; the rest span the whole field range.
    function automatic logic [13:0] random_coord();
        if ($urandom_range(3) == 0)
            return 14'($urandom);
        return 14'($signed($urandom_range(8000)) - 4000);
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_target(random_coord(), random_coord(), random_coord());
    endtask

    task automatic load_geometry(input logic [13:0] bh, input logic [13:0] ul,
                                 input logic [12:0] off, input logic [13:0] fa,
                                 input logic [13:0] tr, input logic [13:0] mh,
                                 input logic [23:0] cs);
        write_geometry(REG_BASE_HEIGHT, bh);
        write_geometry(REG_UPPER_LINK, ul);
        write_geometry(REG_UPPER_OFFSET, off);
        write_geometry(REG_FOREARM, fa);
        write_geometry(REG_TOOL_REACH, tr);
        write_geometry(REG_MARKER_HEIGHT, mh);
        write_geometry(REG_COSINE_SCALE, cs);
    endtask

    initial
    begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_off_cycles = 0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at reset geometry: field extremes, the origin where
        // both atan2 operands are zero, reachable and unreachable targets.
        send_target(14'h1FFF, 14'h1FFF, 14'h1FFF);
        send_target(14'h2000, 14'h2000, 14'h2000);
        send_target(14'h0000, 14'h0000, 14'h0000);
        send_target(14'h2000, 14'h0000, 14'h1FFF);
        send_target(14'h0000, 14'h2000, 14'h0000);
        send_target(14'h3FFF, 14'h0001, 14'h0000);
        send_target(14'h2000, 14'h0001, 14'h0000);
        send_target(14'd2918, 14'd0, 14'd1080);
        send_target(14'd6000, 14'h3F00, 14'd500);
        send_target(14'h3A00, 14'd1500, 14'h3E00);
        drain_results();

        // Extreme geometry drives the angles into saturation and the cosine
        // far beyond its bounds.
        load_geometry(14'h3FFF, 14'h3FFF, 13'd6434, 14'h3FFF, 14'h3FFF, 14'h3FFF,
                      24'hFFFFFF);
        send_target(14'h0000, 14'h0000, 14'h0000);
        send_target(14'h2000, 14'h2000, 14'h2000);
        send_target(14'h1FFF, 14'h1FFF, 14'h1FFF);
        drain_results();
        load_geometry(14'd0, 14'd1, 13'd0, 14'd1, 14'd0, 14'd0, 24'd1);
        send_target(14'h1FFF, 14'h2000, 14'h1FFF);
        send_target(14'h0000, 14'h0000, 14'h0000);
        send_target(14'h0001, 14'h0000, 14'h3FFF);
        drain_results();

        load_geometry(RST_BASE_HEIGHT, RST_UPPER_LINK, RST_UPPER_OFFSET, RST_FOREARM,
                      RST_TOOL_REACH, RST_MARKER_HEIGHT, RST_COSINE_SCALE);
        sender_idle_pct = 35;
        receiver_idle_pct = 87;
        random_phase(150);

        // Long receiver hold-off: the pipeline fills and the input stalls.
        hold_off_cycles = 200;
        sender_idle_pct = 0;
        random_phase(100);
        drain_results();

        load_geometry(14'd1500, 14'd2000, 13'd700, 14'd1800, 14'd1000, 14'd900,
                      24'd130000);
        sender_idle_pct = 87;
        receiver_idle_pct = 35;
        random_phase(120);
        drain_results();

        load_geometry(RST_BASE_HEIGHT, RST_UPPER_LINK, RST_UPPER_OFFSET, RST_FOREARM,
                      RST_TOOL_REACH, RST_MARKER_HEIGHT, RST_COSINE_SCALE);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_phase(130);
        drain_results();

        if (fail_count == 0)
            $display("** four_joint_arm_inverse_kinematics: PASSED **");
        else
            $display("** four_joint_arm_inverse_kinematics: FAILED **");
        $finish;
    end
endmodule

// File: files.f
rtl/fjik_pkg.sv
rtl/fjik_cordic_cell.sv
rtl/fjik_cordic.sv
rtl/fjik_sqrt_cell.sv
rtl/fjik_sqrt.sv
rtl/four_joint_arm_inverse_kinematics.sv
rtl/fjik_checker.sv
dv/fjik_checker.sv
dv/four_joint_arm_inverse_kinematics_tb.sv
